// File: src/mcrm_pkg.sv
// shared types, constants and control interface of the rate meter
package mcrm_pkg;

   localparam int CHANNELS_DEF   = 64;
   localparam int COUNT_BITS_DEF = 48;
   localparam int TIME_BITS_DEF  = 32;

   localparam int RATE_BITS = 40;
   localparam int CSR_BITS  = 12;

   localparam logic [11:0] WINDOW_RESET   = 12'd10;
   localparam logic [6:0]  CHANNELS_RESET = 7'd64;

   typedef enum logic [0:0] {
      CSR_WINDOW_SECONDS  = 1'b0,
      CSR_CHANNELS_IN_USE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  channel;
      logic [15:0] weight;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic [5:0]           rate_channel;
      logic [RATE_BITS-1:0] rate_x16;
      logic                 last_report;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_BURST_READ,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic rd_item;
      logic wr_item;
      logic disp_take;
      logic burst_clear;
      logic rd_burst;
      logic div_start;
      logic out_load;
      logic burst_next;
   } cmd_type;

   typedef struct packed {
      logic item_in_range;
      logic display_due;
      logic burst_empty;
      logic div_busy;
      logic out_free;
      logic burst_last;
   } status_type;

endpackage

// File: src/mcrm_ctrl.sv
// controller state machine sequencing counting and display bursts
module mcrm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mcrm_pkg::status_type status,
   output mcrm_pkg::cmd_type    cmd
);
   import mcrm_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.rd_item = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.wr_item = status.item_in_range;
            if (status.display_due) begin
               cmd.disp_take   = 1'b1;
               cmd.burst_clear = 1'b1;
               state_in        = status.burst_empty ? ST_IDLE : ST_BURST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_BURST_READ: begin
            cmd.rd_burst = 1'b1;
            state_in     = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (!status.div_busy) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.burst_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.burst_next = 1'b1;
                  state_in       = ST_BURST_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: src/mcrm_datapath.sv
// channel memories, window update, rate divider and result register
module mcrm_datapath #(
   parameter int CHANNELS   = mcrm_pkg::CHANNELS_DEF,
   parameter int COUNT_BITS = mcrm_pkg::COUNT_BITS_DEF,
   parameter int TIME_BITS  = mcrm_pkg::TIME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mcrm_pkg::req_type             req_data,
   output mcrm_pkg::rsp_type             rsp_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          csr_write_en,
   input  logic [0:0]                    csr_index,
   input  logic [mcrm_pkg::CSR_BITS-1:0] csr_data,
   input  mcrm_pkg::cmd_type             cmd,
   output mcrm_pkg::status_type          status
);
   import mcrm_pkg::*;

   localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int QW  = COUNT_BITS + 4;
   localparam int XW  = (QW > RATE_BITS) ? QW : RATE_BITS;
   localparam int DCW = $clog2(QW + 1);

   logic [11:0] window_ff;
   logic [6:0]  chan_cfg_ff;
   logic [6:0]  n_act;

   logic [COUNT_BITS-1:0] run_mem [CHANNELS];
   logic [COUNT_BITS-1:0] mkc_mem [CHANNELS];
   logic [TIME_BITS-1:0]  mkt_mem [CHANNELS];
   logic [COUNT_BITS-1:0] wc_mem  [CHANNELS];
   logic [TIME_BITS-1:0]  wt_mem  [CHANNELS];
   logic [CHANNELS-1:0]   vld_ff;

   logic [COUNT_BITS-1:0] rd_run_ff, rd_mkc_ff, rd_wc_ff;
   logic [TIME_BITS-1:0]  rd_mkt_ff, rd_wt_ff;
   logic                  rd_vld_ff;
   logic [COUNT_BITS-1:0] e_run, e_mkc, e_wc;
   logic [TIME_BITS-1:0]  e_mkt, e_wt;
   logic [CW-1:0]         rd_addr;

   logic [7:0]            item_ch_ff;
   logic [15:0]           item_wt_ff;
   logic [TIME_BITS-1:0]  item_now_ff;

   logic [COUNT_BITS-1:0] run_new;
   logic [TIME_BITS-1:0]  elapsed;
   logic                  close_win;

   logic [TIME_BITS-1:0]  disp_time_ff;
   logic                  disp_armed_ff;
   logic [7:0]            bidx_ff;

   logic [QW-1:0]         div_q_ff;
   logic [TIME_BITS:0]    div_r_ff;
   logic [TIME_BITS-1:0]  div_d_ff;
   logic [DCW-1:0]        div_cnt_ff;
   logic                  div_busy_ff;
   logic [TIME_BITS:0]    r_sh;
   logic                  qbit;
   logic [XW-1:0]         q_x;
   logic [RATE_BITS-1:0]  rate;

   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= WINDOW_RESET;
         chan_cfg_ff <= CHANNELS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW_SECONDS:  window_ff   <= csr_data[11:0];
            CSR_CHANNELS_IN_USE: chan_cfg_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   assign n_act = (32'(chan_cfg_ff) > CHANNELS) ? 7'(CHANNELS) : chan_cfg_ff;

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.rd_item) begin
         item_ch_ff  <= req_data.channel;
         item_wt_ff  <= req_data.weight;
         item_now_ff <= TIME_BITS'(req_data.now_seconds);
      end
   end

   // channel memories
   assign rd_addr = cmd.rd_item ? req_data.channel[CW-1:0] : bidx_ff[CW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.rd_item || cmd.rd_burst) begin
         rd_run_ff <= run_mem[rd_addr];
         rd_mkc_ff <= mkc_mem[rd_addr];
         rd_mkt_ff <= mkt_mem[rd_addr];
         rd_wc_ff  <= wc_mem[rd_addr];
         rd_wt_ff  <= wt_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else if (cmd.rd_item || cmd.rd_burst) begin
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign e_run = rd_vld_ff ? rd_run_ff : '0;
   assign e_mkc = rd_vld_ff ? rd_mkc_ff : '0;
   assign e_mkt = rd_vld_ff ? rd_mkt_ff : '0;
   assign e_wc  = rd_vld_ff ? rd_wc_ff  : '0;
   assign e_wt  = rd_vld_ff ? rd_wt_ff  : TIME_BITS'(1);

   assign run_new   = e_run + COUNT_BITS'(item_wt_ff);
   assign elapsed   = item_now_ff - e_mkt;
   assign close_win = elapsed >= TIME_BITS'(window_ff);

   always_ff @(posedge clock) begin
      if (cmd.wr_item) begin
         run_mem[item_ch_ff[CW-1:0]] <= run_new;
         mkc_mem[item_ch_ff[CW-1:0]] <= close_win ? run_new : e_mkc;
         mkt_mem[item_ch_ff[CW-1:0]] <= close_win ? item_now_ff : e_mkt;
         wc_mem[item_ch_ff[CW-1:0]]  <= close_win ? (run_new - e_mkc) : e_wc;
         wt_mem[item_ch_ff[CW-1:0]]  <= close_win ? elapsed : e_wt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.wr_item) begin
         vld_ff[item_ch_ff[CW-1:0]] <= 1'b1;
      end
   end

   // display timing and burst index
   always_ff @(posedge clock) begin
      if (reset) begin
         disp_time_ff  <= '0;
         disp_armed_ff <= 1'b1;
         bidx_ff       <= '0;
      end else begin
         if (cmd.disp_take) begin
            disp_time_ff  <= item_now_ff;
            disp_armed_ff <= 1'b0;
         end
         if (cmd.burst_clear) begin
            bidx_ff <= '0;
         end else if (cmd.burst_next) begin
            bidx_ff <= bidx_ff + 8'd1;
         end
      end
   end

   // restoring divider for window_count * 16 / window_time
   assign r_sh = {div_r_ff[TIME_BITS-1:0], div_q_ff[QW-1]};
   assign qbit = r_sh >= {1'b0, div_d_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_q_ff   <= {e_wc, 4'b0000};
         div_r_ff   <= '0;
         div_d_ff   <= e_wt;
         div_cnt_ff <= DCW'(QW);
      end else if (div_busy_ff) begin
         div_q_ff   <= {div_q_ff[QW-2:0], qbit};
         div_r_ff   <= qbit ? (r_sh - {1'b0, div_d_ff}) : r_sh;
         div_cnt_ff <= div_cnt_ff - DCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1;
      end else if (div_busy_ff && div_cnt_ff == DCW'(1)) begin
         div_busy_ff <= 1'b0;
      end
   end

   assign q_x  = XW'(div_q_ff);
   assign rate = (div_d_ff == '0) ? '0 :
                 (q_x > XW'({RATE_BITS{1'b1}})) ? {RATE_BITS{1'b1}} :
                 q_x[RATE_BITS-1:0];

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.rate_channel <= bidx_ff[5:0];
         rsp_ff.rate_x16     <= rate;
         rsp_ff.last_report  <= status.burst_last;
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   assign status.item_in_range = item_ch_ff < {1'b0, n_act};
   assign status.display_due   = disp_armed_ff || (item_now_ff != disp_time_ff);
   assign status.burst_empty   = n_act == 7'd0;
   assign status.div_busy      = div_busy_ff;
   assign status.out_free      = !rsp_valid_ff || rsp_ready;
   assign status.burst_last    = (bidx_ff + 8'd1) == {1'b0, n_act};

endmodule

// File: src/multi_channel_rate_meter_unit.sv
// top level of the multi-channel windowed rate meter
// Counting reads the channel's entry from the channel memories in the accept
// cycle and writes it back in the next one.
// When a transaction opens a display burst (first after reset or a change of
// now_seconds), one report per channel in use follows; each report is computed
// by the one-bit-per-cycle rate divider and may wait on rsp_ready. No new
// request is accepted during a burst.
module multi_channel_rate_meter_unit #(
   parameter int CHANNELS   = mcrm_pkg::CHANNELS_DEF,
   parameter int COUNT_BITS = mcrm_pkg::COUNT_BITS_DEF,
   parameter int TIME_BITS  = mcrm_pkg::TIME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mcrm_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mcrm_pkg::rsp_type             rsp_data,
   input  logic                          csr_write_en,
   input  logic [0:0]                    csr_index,
   input  logic [mcrm_pkg::CSR_BITS-1:0] csr_data
);
   import mcrm_pkg::*;

   cmd_type    cmd;
   status_type status;

   mcrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mcrm_datapath #(
      .CHANNELS   (CHANNELS),
      .COUNT_BITS (COUNT_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .rsp_data     (rsp_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .status       (status)
   );

   // no two requests in consecutive cycles
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted during update cycle");

   // the last report ends the burst
   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last_report) |=> !rsp_valid)
      else $error("report after end of burst");

   // reports are never loaded while a request can be taken
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load) |-> !req_ready)
      else $error("report loaded while idle");

endmodule
